[hdl/dip_pkg.sv]
package dip_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] LIMIT_TWO_PARTS = 32'h00ff_ffff;
	localparam logic [31:0] LIMIT_THREE_PARTS = 32'h0000_ffff;
	localparam logic [31:0] LIMIT_FOUR_PARTS = 32'h0000_00ff;

	typedef enum logic [2:0] {
		TK_DIGIT,
		TK_HEXL,
		TK_X,
		TK_DOT,
		TK_TERM,
		TK_OTHER
	} tok_class_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_AFTER_ZERO,
		PH_DIGITS,
		PH_FIN,
		PH_BAD
	} phase_t;

	typedef struct packed {
		tok_class_t cls;
		logic [3:0] val;
		logic last;
	} token_t;

	typedef struct packed {
		logic bad;
		logic [31:0] acc;
		logic [2:0][31:0] parts;
		logic [1:0] nsaved;
	} rec_t;

endpackage

[hdl/dip_front.sv]
module dip_front (
	input logic char_valid,
	output logic char_stall,
	input logic [7:0] char_code,
	input logic last,
	input logic q_full,
	output logic push,
	output dip_pkg::token_t tok
);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_LX = 8'h78;

	assign char_stall = q_full;
	assign push = char_valid && !q_full;

	always_comb begin
		tok.last = last;
		tok.val = char_code[3:0];
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			tok.cls = dip_pkg::TK_DIGIT;
		end else if ((char_code >= CH_LA && char_code <= CH_LF) ||
				(char_code >= CH_UA && char_code <= CH_UF)) begin
			tok.cls = dip_pkg::TK_HEXL;
			tok.val = char_code[3:0] + 4'd9;
		end else if (char_code == CH_LX || char_code == CH_UX) begin
			tok.cls = dip_pkg::TK_X;
		end else if (char_code == CH_DOT) begin
			tok.cls = dip_pkg::TK_DOT;
		end else if (char_code == CH_NUL || char_code == CH_SPACE ||
				(char_code >= CH_TAB && char_code <= CH_CR)) begin
			tok.cls = dip_pkg::TK_TERM;
		end else begin
			tok.cls = dip_pkg::TK_OTHER;
		end
	end

endmodule

[hdl/dip_queue.sv]
module dip_queue #(
	parameter int DEPTH = dip_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input dip_pkg::token_t push_tok,
	input logic pop,
	output dip_pkg::token_t head_tok,
	output logic empty,
	output logic full
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	dip_pkg::token_t tok_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == FULL_COUNT);
	assign head_tok = tok_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			tok_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/dip_parse.sv]
module dip_parse (
	input logic clk,
	input logic arst_n,
	input logic tok_valid,
	input dip_pkg::token_t tok,
	input logic rec_ready,
	output logic pop,
	output logic rec_push,
	output dip_pkg::rec_t rec
);

	dip_pkg::phase_t phase_q, phase_n;
	dip_pkg::radix_t radix_q, radix_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0][31:0] parts_q, parts_n;
	logic [1:0] nsaved_q, nsaved_n;
	logic step;
	logic [31:0] acc_dec, acc_oct, acc_hex, acc_digit;

	assign step = tok_valid && (!tok.last || rec_ready);
	assign pop = step;
	assign rec_push = step && tok.last;

	assign acc_dec = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0} + {28'd0, tok.val};
	assign acc_oct = {acc_q[28:0], 3'b000} + {28'd0, tok.val};
	assign acc_hex = {acc_q[27:0], tok.val};

	always_comb begin
		case (radix_q)
			dip_pkg::RADIX_HEX: acc_digit = acc_hex;
			dip_pkg::RADIX_OCT: acc_digit = acc_oct;
			default: acc_digit = acc_dec;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		radix_n = radix_q;
		acc_n = acc_q;
		parts_n = parts_q;
		nsaved_n = nsaved_q;
		case (phase_q)
			dip_pkg::PH_FIRST: begin
				if (tok.cls != dip_pkg::TK_DIGIT) begin
					phase_n = dip_pkg::PH_BAD;
				end else if (tok.val == 4'd0) begin
					acc_n = '0;
					radix_n = dip_pkg::RADIX_OCT;
					phase_n = dip_pkg::PH_AFTER_ZERO;
				end else begin
					acc_n = {28'd0, tok.val};
					radix_n = dip_pkg::RADIX_DEC;
					phase_n = dip_pkg::PH_DIGITS;
				end
			end
			dip_pkg::PH_AFTER_ZERO, dip_pkg::PH_DIGITS: begin
				phase_n = dip_pkg::PH_DIGITS;
				if (phase_q == dip_pkg::PH_AFTER_ZERO && tok.cls == dip_pkg::TK_X) begin
					radix_n = dip_pkg::RADIX_HEX;
				end else begin
					case (tok.cls)
						dip_pkg::TK_DIGIT: acc_n = acc_digit;
						dip_pkg::TK_HEXL: begin
							if (radix_q == dip_pkg::RADIX_HEX) begin
								acc_n = acc_hex;
							end else begin
								phase_n = dip_pkg::PH_BAD;
							end
						end
						dip_pkg::TK_DOT: begin
							if (nsaved_q == 2'd3) begin
								phase_n = dip_pkg::PH_BAD;
							end else begin
								for (int i = 0; i < 3; i++) begin
									if (nsaved_q == 2'(i)) begin
										parts_n[i] = acc_q;
									end
								end
								nsaved_n = nsaved_q + 2'd1;
								acc_n = '0;
								radix_n = dip_pkg::RADIX_DEC;
								phase_n = dip_pkg::PH_FIRST;
							end
						end
						dip_pkg::TK_TERM: phase_n = dip_pkg::PH_FIN;
						default: phase_n = dip_pkg::PH_BAD;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// A string that ends where a part must begin is rejected; any other open
	// part is closed as if a terminator followed.
	always_comb begin
		rec.bad = (phase_n == dip_pkg::PH_FIRST) || (phase_n == dip_pkg::PH_BAD);
		rec.acc = acc_n;
		rec.parts = parts_n;
		rec.nsaved = nsaved_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dip_pkg::PH_FIRST;
			radix_q <= dip_pkg::RADIX_DEC;
			acc_q <= '0;
			parts_q <= '0;
			nsaved_q <= '0;
		end else if (step) begin
			if (tok.last) begin
				phase_q <= dip_pkg::PH_FIRST;
				radix_q <= dip_pkg::RADIX_DEC;
				acc_q <= '0;
				parts_q <= '0;
				nsaved_q <= '0;
			end else begin
				phase_q <= phase_n;
				radix_q <= radix_n;
				acc_q <= acc_n;
				parts_q <= parts_n;
				nsaved_q <= nsaved_n;
			end
		end
	end

endmodule

[hdl/dip_finish.sv]
module dip_finish (
	input logic clk,
	input logic arst_n,
	input logic rec_push,
	input dip_pkg::rec_t rec,
	output logic rec_ready,
	output logic res_valid,
	input logic res_stall,
	output logic valid_res,
	output logic [31:0] address,
	output logic [2:0] part_count
);

	dip_pkg::rec_t rec_s1;
	logic rec_valid_s1;
	logic out_valid_q;
	logic out_load;
	logic ok;
	logic [31:0] addr;
	logic [31:0] valid_res_q_unused_guard;
	logic valid_res_q;
	logic [31:0] address_q;
	logic [2:0] part_count_q;

	assign out_load = rec_valid_s1 && (!out_valid_q || !res_stall);
	assign rec_ready = !rec_valid_s1 || out_load;
	assign valid_res_q_unused_guard = address_q;

	always_comb begin
		case (rec_s1.nsaved)
			2'd0: begin
				ok = 1'b1;
				addr = rec_s1.acc;
			end
			2'd1: begin
				ok = rec_s1.acc <= dip_pkg::LIMIT_TWO_PARTS;
				addr = rec_s1.acc | {rec_s1.parts[0][7:0], 24'd0};
			end
			2'd2: begin
				ok = rec_s1.acc <= dip_pkg::LIMIT_THREE_PARTS;
				addr = rec_s1.acc | {rec_s1.parts[0][7:0], 24'd0} |
					{rec_s1.parts[1][15:0], 16'd0};
			end
			default: begin
				ok = rec_s1.acc <= dip_pkg::LIMIT_FOUR_PARTS;
				addr = rec_s1.acc | {rec_s1.parts[0][7:0], 24'd0} |
					{rec_s1.parts[1][15:0], 16'd0} | {rec_s1.parts[2][23:0], 8'd0};
			end
		endcase
		ok = ok && !rec_s1.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_ready) begin
				rec_valid_s1 <= rec_push;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_ready && rec_push) begin
			rec_s1 <= rec;
		end
		if (out_load) begin
			valid_res_q <= ok;
			address_q <= ok ? addr : 32'd0;
			part_count_q <= ok ? {1'b0, rec_s1.nsaved} + 3'd1 : 3'd0;
		end
	end

	assign res_valid = out_valid_q;
	assign valid_res = valid_res_q;
	assign address = valid_res_q_unused_guard;
	assign part_count = part_count_q;

endmodule

[hdl/dotted_ipv4_text_parser_top.sv]
// Parses dotted IPv4 text in the classic loose dotted form, one character word per clock:
// decimal, octal after a leading zero or hex after 0x parts, one to four of them, with the
// part accumulator wrapping at 32 bits. Only the word marked last yields a result word,
// carrying the verdict, the address and the part count; that word's record then passes the
// finish stage's record register and the output register that drives res_valid. Characters
// go through a classifier into a small queue, so the input keeps taking one word per cycle
// while a result waits on the output, until the queue fills; the parser sets the rate of one
// character per clock while the queue is not empty and no last word waits, folding in each
// digit with shift-adds. A character sent while the queue is full is held off by char_stall.
module dotted_ipv4_text_parser_top #(
	parameter int QUEUE_DEPTH = dip_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_stall,
	input logic [7:0] char_code,
	input logic last,
	output logic res_valid,
	input logic res_stall,
	output logic valid_res,
	output logic [31:0] address,
	output logic [2:0] part_count
);

	dip_pkg::token_t front_tok;
	dip_pkg::token_t head_tok;
	dip_pkg::rec_t rec;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	logic rec_push;
	logic rec_ready;

	dip_front u_front (
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.last(last),
		.q_full(q_full),
		.push(push),
		.tok(front_tok)
	);

	dip_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_tok(front_tok),
		.pop(pop),
		.head_tok(head_tok),
		.empty(q_empty),
		.full(q_full)
	);

	dip_parse u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.tok_valid(!q_empty),
		.tok(head_tok),
		.rec_ready(rec_ready),
		.pop(pop),
		.rec_push(rec_push),
		.rec(rec)
	);

	dip_finish u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.rec_push(rec_push),
		.rec(rec),
		.rec_ready(rec_ready),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.valid_res(valid_res),
		.address(address),
		.part_count(part_count)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && valid_res |-> part_count != 3'd0 && part_count <= 3'd4)
		else $error("accepted address carries a bad part count");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !valid_res |-> address == 32'd0 && part_count == 3'd0)
		else $error("rejected string carries a nonzero address or count");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(q_empty && q_full))
		else $error("queue is both empty and full");

	assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> rec_ready && !q_empty)
		else $error("parser closed a string with nowhere to put it");

endmodule
